[rtl/pea_pkg.sv]
// Shared constants and types for the page extent allocator.
package pea_pkg;

  localparam int unsigned DefMaxExtents = 64;
  localparam int unsigned DefPageBits   = 16;

  localparam int unsigned CountW  = 17;
  localparam int unsigned AlignW  = 16;
  localparam int unsigned PageOW  = 16;
  localparam int unsigned AvailW  = 17;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;

  localparam logic OPC_ALLOC   = 1'b0;
  localparam logic OPC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

[rtl/page_extent_allocator.sv]
// Top level of the page extent allocator: sequencer, table walk and result register.
//
//  port group   dir  tdata fields (low bit up)                       tuser
//  s_axis       in   page_count, alignment, first_page, last_page    opcode
//  m_axis       out  ok, status, page, available_pages               -
//
// An allocate walks the extents from the last entry down, skipping any too small for the run,
// then writes the table and moves entries to insert or delete one.
// A release walks up past the extents below first_page, then writes and moves entries the same way.
// The walk and moves go through the single port pair of the extent table, read one entry at a time.
// No clearing pass is needed after reset; the table is empty and the count is zero.
// A finished result waits in the output register; the next request is taken meanwhile.
module page_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = pea_pkg::DefMaxExtents,
  parameter int unsigned PAGE_BITS   = pea_pkg::DefPageBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // page_count[16:0], alignment[32:17], first_page[48:33], last_page[64:49], zero pad.
  input  logic [pea_pkg::InDataW-1:0]   s_axis_tdata,
  // opcode[0].
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // ok[0], status[2:1], page[18:3], available_pages[35:19], zero pad.
  output logic [pea_pkg::OutDataW-1:0]  m_axis_tdata
);

  import pea_pkg::*;

  localparam int unsigned AI = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned SW = PAGE_BITS + 1;
  localparam int unsigned EW = PAGE_BITS + SW;
  localparam int unsigned AW = ((PAGE_BITS > 17) ? PAGE_BITS : 17) + 3;
  localparam logic [AW-1:0] PMASK = AW'({PAGE_BITS{1'b1}});
  localparam logic [CW-1:0] CMAX = CW'(MAX_EXTENTS);

  typedef enum logic [4:0] {
    S_IDLE, S_SUB, S_ARD, S_AE1, S_AE2, S_AE3, S_AE4, S_ADEC,
    S_RRD, S_RCAP, S_RDEC, S_WR1, S_OPSTART,
    S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR, S_DONE
  } state_e;

  typedef enum logic [1:0] {OP_NONE, OP_INS, OP_DEL} op_e;

  state_e          state_q;
  op_e             op_q;
  status_e         res_st_q;
  logic [AW-1:0]   res_page_q;
  logic [AW-1:0]   n_q, lo_q, hi_q, mask_q, sub_q, size_q, free_q;
  logic [AW-1:0]   ps_q, pe_q, is_q, ie_q;
  logic [AW-1:0]   prev_s_q, prev_z_q, next_s_q, next_z_q;
  logic            a_nz_q, have_prev_q, have_next_q;
  logic [CW-1:0]   count_q, k_q, j_q, op_pos_q;
  logic [AI-1:0]   act_addr_q;
  logic [EW-1:0]   act_data_q, ins_data_q;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic            ram_we;
  logic [AI-1:0]   ram_waddr, ram_raddr;
  logic [EW-1:0]   ram_wdata, ram_rdata;
  logic [AW-1:0]   ent_s, ent_z;

  logic [AW-1:0]   in_n, in_a, in_lo, in_hi;
  logic [AW-1:0]   lower, upper, prev_end, m_val;
  logic            back, fwd;

  assign in_n  = AW'(s_axis_tdata[16:0]);
  assign in_a  = AW'(s_axis_tdata[32:17]);
  assign in_lo = AW'(s_axis_tdata[48:33]) & PMASK;
  assign in_hi = AW'(s_axis_tdata[64:49]) & PMASK;

  assign ent_s = AW'(ram_rdata[PAGE_BITS-1:0]);
  assign ent_z = AW'(ram_rdata[EW-1:PAGE_BITS]);

  assign lower    = ie_q + AW'(1) - n_q - ps_q;
  assign upper    = pe_q - ie_q;
  assign prev_end = prev_s_q + prev_z_q;
  assign m_val    = ie_q & mask_q;
  assign back     = have_prev_q && (prev_end == lo_q);
  assign fwd      = have_next_q && (lo_q + size_q == next_s_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  pea_ram #(.Width(EW), .Depth(MAX_EXTENTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_q)
      S_ARD: ram_raddr = AI'(k_q - CW'(1));
      S_RRD: ram_raddr = AI'(j_q);
      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = act_addr_q;
        ram_wdata = act_data_q;
      end
      S_INS_RD: begin
        if (j_q > op_pos_q) begin
          ram_raddr = AI'(j_q - CW'(1));
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AI'(op_pos_q);
          ram_wdata = ins_data_q;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AI'(j_q);
        ram_wdata = ram_rdata;
      end
      S_DEL_RD: ram_raddr = AI'(j_q);
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AI'(j_q - CW'(1));
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      count_q     <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
      res_st_q    <= ST_OK;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            n_q         <= in_n;
            lo_q        <= in_lo;
            hi_q        <= in_hi;
            a_nz_q      <= (in_a != '0);
            mask_q      <= ~(in_a - AW'(1));
            size_q      <= in_hi - in_lo + AW'(1);
            res_page_q  <= '0;
            have_prev_q <= 1'b0;
            have_next_q <= 1'b0;
            j_q         <= '0;
            op_q        <= OP_NONE;
            if (s_axis_tuser == OPC_ALLOC) begin
              state_q <= S_SUB;
            end else if (in_hi < in_lo) begin
              res_st_q <= ST_BAD_COUNT;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_RRD;
            end
          end
        end
        S_SUB: begin
          k_q <= count_q;
          if (a_nz_q) begin
            sub_q <= ((n_q + ~mask_q) & mask_q) - n_q + AW'(1);
          end else begin
            sub_q <= '0;
          end
          if (n_q == '0 || n_q > free_q) begin
            res_st_q <= ST_BAD_COUNT;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_ARD;
          end
        end
        S_ARD: begin
          if (k_q == '0) begin
            res_st_q <= ST_NO_FIT;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_AE1;
          end
        end
        S_AE1: begin
          ps_q <= ent_s;
          pe_q <= ent_s + ent_z - AW'(1);
          if (ent_z < n_q) begin
            k_q     <= k_q - CW'(1);
            state_q <= S_ARD;
          end else begin
            state_q <= S_AE2;
          end
        end
        S_AE2: begin
          is_q <= (lo_q >= ps_q) ? lo_q : ps_q;
          ie_q <= (hi_q <= pe_q) ? hi_q : pe_q;
          if (!a_nz_q) begin
            state_q <= S_AE4;
          end else begin
            state_q <= S_AE3;
          end
        end
        S_AE3: begin
          if ((ie_q < is_q) || (ie_q - is_q + AW'(1) < n_q) || (m_val < sub_q)) begin
            k_q     <= k_q - CW'(1);
            state_q <= S_ARD;
          end else begin
            ie_q    <= m_val - sub_q;
            state_q <= S_AE4;
          end
        end
        S_AE4: begin
          if ((ie_q < is_q) || (ie_q - is_q + AW'(1) < n_q)) begin
            k_q     <= k_q - CW'(1);
            state_q <= S_ARD;
          end else begin
            state_q <= S_ADEC;
          end
        end
        S_ADEC: begin
          act_addr_q <= AI'(k_q - CW'(1));
          if (lower != '0 && upper != '0 && count_q >= CMAX) begin
            res_st_q <= ST_FULL;
            state_q  <= S_DONE;
          end else begin
            res_st_q   <= ST_OK;
            free_q     <= free_q - n_q;
            res_page_q <= ie_q + AW'(1) - n_q;
            op_pos_q   <= (lower == '0 && upper == '0) ? k_q - CW'(1) : k_q;
            ins_data_q <= {SW'(upper), PAGE_BITS'(ie_q + AW'(1))};
            if (lower != '0) begin
              act_data_q <= {SW'(lower), PAGE_BITS'(ps_q)};
              op_q       <= (upper != '0) ? OP_INS : OP_NONE;
              state_q    <= S_WR1;
            end else if (upper != '0) begin
              act_data_q <= {SW'(upper), PAGE_BITS'(ie_q + AW'(1))};
              state_q    <= S_WR1;
            end else begin
              op_q     <= OP_DEL;
              state_q  <= S_OPSTART;
            end
          end
        end
        S_RRD: begin
          if (j_q < count_q) begin
            state_q <= S_RCAP;
          end else begin
            op_pos_q <= j_q;
            state_q  <= S_RDEC;
          end
        end
        S_RCAP: begin
          if (ent_s < lo_q) begin
            prev_s_q    <= ent_s;
            prev_z_q    <= ent_z;
            have_prev_q <= 1'b1;
            j_q         <= j_q + CW'(1);
            state_q     <= S_RRD;
          end else begin
            next_s_q    <= ent_s;
            next_z_q    <= ent_z;
            have_next_q <= 1'b1;
            op_pos_q    <= j_q;
            state_q     <= S_RDEC;
          end
        end
        S_RDEC: begin
          ins_data_q <= {SW'(size_q), PAGE_BITS'(lo_q)};
          if ((have_prev_q && prev_end > lo_q) || (have_next_q && next_s_q <= hi_q)) begin
            res_st_q <= ST_BAD_COUNT;
            state_q  <= S_DONE;
          end else if (!back && !fwd && count_q >= CMAX) begin
            res_st_q <= ST_FULL;
            state_q  <= S_DONE;
          end else begin
            res_st_q <= ST_OK;
            free_q   <= free_q + size_q;
            if (back && fwd) begin
              act_addr_q <= AI'(op_pos_q - CW'(1));
              act_data_q <= {SW'(prev_z_q + size_q + next_z_q), PAGE_BITS'(prev_s_q)};
              op_q       <= OP_DEL;
              state_q    <= S_WR1;
            end else if (back) begin
              act_addr_q <= AI'(op_pos_q - CW'(1));
              act_data_q <= {SW'(prev_z_q + size_q), PAGE_BITS'(prev_s_q)};
              state_q    <= S_WR1;
            end else if (fwd) begin
              act_addr_q <= AI'(op_pos_q);
              act_data_q <= {SW'(next_z_q + size_q), PAGE_BITS'(lo_q)};
              state_q    <= S_WR1;
            end else begin
              op_q    <= OP_INS;
              state_q <= S_OPSTART;
            end
          end
        end
        S_WR1: begin
          state_q <= S_OPSTART;
        end
        S_OPSTART: begin
          case (op_q)
            OP_INS: begin
              j_q     <= count_q;
              state_q <= S_INS_RD;
            end
            OP_DEL: begin
              j_q     <= op_pos_q + CW'(1);
              state_q <= S_DEL_RD;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_INS_RD: begin
          if (j_q > op_pos_q) begin
            state_q <= S_INS_WR;
          end else begin
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end
        end
        S_INS_WR: begin
          j_q     <= j_q - CW'(1);
          state_q <= S_INS_RD;
        end
        S_DEL_RD: begin
          if (j_q < count_q) begin
            state_q <= S_DEL_WR;
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end
        end
        S_DEL_WR: begin
          j_q     <= j_q + CW'(1);
          state_q <= S_DEL_RD;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= OutDataW'({AvailW'(free_q),
                                      (res_st_q == ST_OK) ? PageOW'(res_page_q) : PageOW'(0),
                                      res_st_q, (res_st_q == ST_OK)});
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CMAX) else $error("extent count above table size");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INS_RD && state_q != S_DEL_RD) |=> $stable(count_q))
    else $error("extent count changed outside insert or delete");

  a_fail_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[2:1] != ST_OK) |-> (out_data_q[18:3] == '0 && !out_data_q[0]))
    else $error("failed transaction carries a page");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while a transaction is in progress");

endmodule

[rtl/pea_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pea_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
